/* design/ltteb_pkg.sv */
// ----------------------------------------------------------------------------
// ltteb_pkg
// Shared widths, reset values, register codes, controller/datapath bundles
// and the cosine table generator for the lidar time-to-collision brake.
// ----------------------------------------------------------------------------
package ltteb_pkg;

	// default depth of the cosine table over the full circle
	localparam int COS_TABLE_DEPTH = 256;

	// field widths
	localparam int ANGLE_W    = 16;
	localparam int STEP_W     = 13;
	localparam int LIMIT_W    = 16;
	localparam int SPEED_W    = 16;
	localparam int RANGE_W    = 16;
	localparam int BEAM_W     = 18;
	localparam int COS_W      = 16;
	localparam int RATE_W     = 32;
	localparam int RATE_POS_W = 30;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int TDATA_IN_W  = 32;
	localparam int TUSER_IN_W  = 2;
	localparam int TDATA_OUT_W = 8;

	// product and comparison widths of the critical test
	localparam int RANGE_K_W = 26;
	localparam int LHS_W     = RANGE_K_W + 14;
	localparam int RHS_W     = LIMIT_W + RATE_POS_W;
	localparam int MS_PER_S  = 1000;

	// register reset values
	localparam logic signed [ANGLE_W-1:0] ANGLE_START_RST = -16'sd24576;
	localparam logic signed [ANGLE_W-1:0] ANGLE_STOP_RST  = 16'sd24576;
	localparam logic [STEP_W-1:0]         ANGLE_STEP_RST  = 13'd45;
	localparam logic [LIMIT_W-1:0]        TTC_LIMIT_RST   = 16'd1250;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_START = 2'd0,
		REG_ANGLE_STOP  = 2'd1,
		REG_ANGLE_STEP  = 2'd2,
		REG_TTC_LIMIT   = 2'd3
	} cfg_reg_t;

	// controller to datapath commands
	typedef struct packed {
		logic take_speed;
		logic take_sample;
		logic ld_rate;
		logic ld_test;
		logic finish;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic sample_last;
		logic out_busy;
	} dp_status_t;

	// quarter-wave sine, z in Q14 from 0 to 16384
	function automatic int quarter_sin(int z);
		int z2;
		int t;
		z2 = (z * z) >>> 14;
		t  = 10584 - ((z2 * 1232) >>> 14);
		t  = 25736 - ((z2 * t) >>> 14);
		return (z * t) >>> 14;
	endfunction

	// Q14 cosine of a 16-bit binary angle
	function automatic int cos_q14(int a);
		int q;
		int r;
		q = (a >>> 14) & 3;
		r = a & 16'h3FFF;
		case (q)
			0: return quarter_sin(16384 - r);
			1: return -quarter_sin(r);
			2: return -quarter_sin(16384 - r);
			default: return quarter_sin(r);
		endcase
	endfunction

endpackage

/* design/ltteb_cos_rom.sv */
// ----------------------------------------------------------------------------
// ltteb_cos_rom
// Constant cosine table over the full circle with a registered read port.
// ----------------------------------------------------------------------------
module ltteb_cos_rom #(
	parameter int DEPTH = ltteb_pkg::COS_TABLE_DEPTH
) (
	input  logic                                  clk,
	input  logic [$clog2(DEPTH)-1:0]              addr,
	output logic signed [ltteb_pkg::COS_W-1:0]    data
);

	logic signed [ltteb_pkg::COS_W-1:0] tab [DEPTH];
	logic signed [ltteb_pkg::COS_W-1:0] data_q;

	// entry i holds the cosine of angle floor(i * 65536 / depth)
	for (genvar g = 0; g < DEPTH; g++) begin : g_tab
		assign tab[g] = ltteb_pkg::COS_W'(ltteb_pkg::cos_q14((g * 65536) / DEPTH));
	end

	// registered read
	always_ff @(posedge clk) begin
		data_q <= tab[addr];
	end

	assign data = data_q;

endmodule

/* design/ltteb_ctrl.sv */
// ----------------------------------------------------------------------------
// ltteb_ctrl
// Sequencer: takes one item at a time and walks a range sample through
// table read, rate multiply, threshold multiply and final compare.
// ----------------------------------------------------------------------------
module ltteb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  item_cmd,
	output logic                  s_tready,
	output ltteb_pkg::dp_cmd_t    dp_cmd,
	input  ltteb_pkg::dp_status_t dp_status
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOOK = 5'b00010,
		ST_RATE = 5'b00100,
		ST_TEST = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   finish_ok;

	// a last sample waits while the result register is still full
	assign finish_ok = !(dp_status.sample_last && dp_status.out_busy);

	// command decode
	always_comb begin
		s_tready            = (state_q == ST_IDLE);
		dp_cmd.take_speed   = (state_q == ST_IDLE) && s_tvalid && !item_cmd;
		dp_cmd.take_sample  = (state_q == ST_IDLE) && s_tvalid && item_cmd;
		dp_cmd.ld_rate      = (state_q == ST_RATE);
		dp_cmd.ld_test      = (state_q == ST_TEST);
		dp_cmd.finish       = (state_q == ST_DONE) && finish_ok;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && item_cmd) state_d = ST_LOOK;
			end
			ST_LOOK: state_d = ST_RATE;
			ST_RATE: state_d = ST_TEST;
			ST_TEST: state_d = ST_DONE;
			ST_DONE: begin
				if (finish_ok) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/ltteb_datapath.sv */
// ----------------------------------------------------------------------------
// ltteb_datapath
// Configuration registers, speed and beam angle state, table index, the two
// multiplies of the closing-rate test, scan accumulation and result register.
// ----------------------------------------------------------------------------
module ltteb_datapath #(
	parameter int DEPTH = ltteb_pkg::COS_TABLE_DEPTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ltteb_pkg::dp_cmd_t                     dp_cmd,
	output ltteb_pkg::dp_status_t                  dp_status,
	input  logic                                   cfg_we,
	input  logic [ltteb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ltteb_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic signed [ltteb_pkg::SPEED_W-1:0]   speed_mm_s,
	input  logic [ltteb_pkg::RANGE_W-1:0]          range_mm,
	input  logic                                   range_valid,
	input  logic                                   last_beam,
	output logic [$clog2(DEPTH)-1:0]               rom_addr,
	input  logic signed [ltteb_pkg::COS_W-1:0]     rom_data,
	input  logic                                   m_tready,
	output logic                                   m_tvalid,
	output logic                                   brake
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int SUM_W = 17 + IDX_W;

	// configuration registers
	logic signed [ltteb_pkg::ANGLE_W-1:0] start_q;
	logic signed [ltteb_pkg::ANGLE_W-1:0] stop_q;
	logic [ltteb_pkg::STEP_W-1:0]         step_q;
	logic [ltteb_pkg::LIMIT_W-1:0]        limit_q;

	// scan state
	logic signed [ltteb_pkg::SPEED_W-1:0] speed_q;
	logic signed [ltteb_pkg::BEAM_W-1:0]  beam_q;
	logic                                 danger_q;

	// sample stages
	logic [IDX_W-1:0]                     idx_s1;
	logic [ltteb_pkg::RANGE_W-1:0]        range_s1;
	logic                                 valid_s1;
	logic                                 last_s1;
	logic                                 win_s1;
	logic signed [ltteb_pkg::RATE_W-1:0]  rate_s2;
	logic                                 pos_s3;
	logic [ltteb_pkg::LHS_W-1:0]          lhs_s3;
	logic [ltteb_pkg::RHS_W-1:0]          rhs_s3;

	// result register
	logic out_valid_q;
	logic brake_q;

	logic signed [ltteb_pkg::BEAM_W-1:0]  start_ext;
	logic signed [ltteb_pkg::BEAM_W-1:0]  stop_ext;
	logic signed [ltteb_pkg::BEAM_W-1:0]  step_ext;
	logic                                 in_window;
	logic [SUM_W-1:0]                     idx_sum;
	logic [IDX_W:0]                       idx_raw;
	logic [IDX_W:0]                       idx_wrap;
	logic [ltteb_pkg::RANGE_K_W-1:0]      range_k;
	logic                                 critical;
	logic                                 hit;

	assign start_ext = {{(ltteb_pkg::BEAM_W - ltteb_pkg::ANGLE_W){start_q[ltteb_pkg::ANGLE_W-1]}},
		start_q};
	assign stop_ext  = {{(ltteb_pkg::BEAM_W - ltteb_pkg::ANGLE_W){stop_q[ltteb_pkg::ANGLE_W-1]}},
		stop_q};
	assign step_ext  = $signed({{(ltteb_pkg::BEAM_W - ltteb_pkg::STEP_W){1'b0}}, step_q});
	assign in_window = (beam_q <= stop_ext);

	// nearest table index of the wrapped 16-bit angle, modulo the depth
	assign idx_sum  = SUM_W'(beam_q[ltteb_pkg::ANGLE_W-1:0]) * SUM_W'(DEPTH) + SUM_W'(32768);
	assign idx_raw  = idx_sum[SUM_W-1:16];
	assign idx_wrap = (idx_raw >= (IDX_W+1)'(DEPTH)) ? idx_raw - (IDX_W+1)'(DEPTH) : idx_raw;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= ltteb_pkg::ANGLE_START_RST;
			stop_q  <= ltteb_pkg::ANGLE_STOP_RST;
			step_q  <= ltteb_pkg::ANGLE_STEP_RST;
			limit_q <= ltteb_pkg::TTC_LIMIT_RST;
		end else if (cfg_we) begin
			case (ltteb_pkg::cfg_reg_t'(cfg_index))
				ltteb_pkg::REG_ANGLE_START: start_q <= cfg_wdata;
				ltteb_pkg::REG_ANGLE_STOP:  stop_q  <= cfg_wdata;
				ltteb_pkg::REG_ANGLE_STEP:  step_q  <= cfg_wdata[ltteb_pkg::STEP_W-1:0];
				ltteb_pkg::REG_TTC_LIMIT:   limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// speed and beam angle; the angle holds once past the stop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			beam_q  <= {{(ltteb_pkg::BEAM_W - ltteb_pkg::ANGLE_W)
				{ltteb_pkg::ANGLE_START_RST[ltteb_pkg::ANGLE_W-1]}},
				ltteb_pkg::ANGLE_START_RST};
		end else begin
			if (dp_cmd.take_speed) begin
				speed_q <= speed_mm_s;
			end
			if (cfg_we && (ltteb_pkg::cfg_reg_t'(cfg_index) == ltteb_pkg::REG_ANGLE_START)) begin
				beam_q <= {{(ltteb_pkg::BEAM_W - ltteb_pkg::ANGLE_W)
					{cfg_wdata[ltteb_pkg::ANGLE_W-1]}}, cfg_wdata};
			end else if (dp_cmd.take_sample) begin
				if (last_beam) begin
					beam_q <= start_ext;
				end else if (in_window) begin
					beam_q <= beam_q + step_ext;
				end
			end
		end
	end

	// capture the sample and its table index
	always_ff @(posedge clk) begin
		if (dp_cmd.take_sample) begin
			idx_s1   <= idx_wrap[IDX_W-1:0];
			range_s1 <= range_mm;
			valid_s1 <= range_valid;
			last_s1  <= last_beam;
			win_s1   <= in_window;
		end
	end

	assign rom_addr = idx_s1;

	// closing rate in Q14 mm/s
	always_ff @(posedge clk) begin
		if (dp_cmd.ld_rate) begin
			rate_s2 <= ltteb_pkg::RATE_W'(speed_q) * ltteb_pkg::RATE_W'(rom_data);
		end
	end

	// both sides of range * 1000 * 2^14 < limit * rate
	assign range_k = ltteb_pkg::RANGE_K_W'(range_s1) * ltteb_pkg::RANGE_K_W'(ltteb_pkg::MS_PER_S);

	always_ff @(posedge clk) begin
		if (dp_cmd.ld_test) begin
			pos_s3 <= (rate_s2 > 0);
			lhs_s3 <= {range_k, 14'd0};
			rhs_s3 <= ltteb_pkg::RHS_W'(limit_q) *
				ltteb_pkg::RHS_W'(rate_s2[ltteb_pkg::RATE_POS_W-1:0]);
		end
	end

	assign critical = win_s1 && valid_s1 && pos_s3 && (ltteb_pkg::RHS_W'(lhs_s3) < rhs_s3);
	assign hit      = danger_q || critical;

	// scan accumulation and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			danger_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.finish) begin
				danger_q <= last_s1 ? 1'b0 : hit;
			end
			if (dp_cmd.finish && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.finish && last_s1) begin
			brake_q <= hit;
		end
	end

	assign dp_status.sample_last = last_s1;
	assign dp_status.out_busy    = out_valid_q && !m_tready;
	assign m_tvalid              = out_valid_q;
	assign brake                 = brake_q;

endmodule

/* design/lidar_ttc_emergency_brake.sv */
// ----------------------------------------------------------------------------
// lidar_ttc_emergency_brake
// Time-to-collision brake over one lidar sweep: keeps the vehicle speed,
// steps a beam angle per range sample, and flags the scan when a beam closes
// faster than the configured limit allows.
//
//   channel   direction  content
//   s_*       in         item: tuser cmd/range_valid, tdata speed/range, tlast
//   m_*       out        result: tdata brake, one per last sample
//   cfg_*     in         register write: index, data
//
// A speed update is taken as it arrives. A range sample passes through table
// read, rate multiply, threshold multiply and compare, in that order. A last
// sample waits in its final step while the result register still holds an
// untaken result. Reset is asynchronous, active low, and loads the default
// register values and an empty scan.
// ----------------------------------------------------------------------------
module lidar_ttc_emergency_brake #(
	parameter int COS_TABLE_DEPTH = ltteb_pkg::COS_TABLE_DEPTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// [15:0] speed_mm_s, [31:16] range_mm
	input  logic [ltteb_pkg::TDATA_IN_W-1:0]       s_tdata,
	// [0] cmd, [1] range_valid
	input  logic [ltteb_pkg::TUSER_IN_W-1:0]       s_tuser,
	input  logic                                   s_tlast,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [0] brake, [7:1] zero
	output logic [ltteb_pkg::TDATA_OUT_W-1:0]      m_tdata,
	input  logic                                   cfg_we,
	input  logic [ltteb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ltteb_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	localparam int IDX_W = $clog2(COS_TABLE_DEPTH);

	ltteb_pkg::dp_cmd_t                  dp_cmd;
	ltteb_pkg::dp_status_t               dp_status;
	logic [IDX_W-1:0]                    rom_addr;
	logic signed [ltteb_pkg::COS_W-1:0]  rom_data;
	logic                                brake;

	// sequencer
	ltteb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.item_cmd  (s_tuser[0]),
		.s_tready  (s_tready),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status)
	);

	// cosine table
	ltteb_cos_rom #(
		.DEPTH (COS_TABLE_DEPTH)
	) u_cos_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	// datapath
	ltteb_datapath #(
		.DEPTH (COS_TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.dp_status   (dp_status),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.speed_mm_s  (s_tdata[15:0]),
		.range_mm    (s_tdata[31:16]),
		.range_valid (s_tuser[1]),
		.last_beam   (s_tlast),
		.rom_addr    (rom_addr),
		.rom_data    (rom_data),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.brake       (brake)
	);

	assign m_tdata = {{(ltteb_pkg::TDATA_OUT_W-1){1'b0}}, brake};

endmodule

/* design/ltteb_checker.sv */
// ----------------------------------------------------------------------------
// ltteb_checker
// Port-level checks of the brake block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ltteb_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [ltteb_pkg::TUSER_IN_W-1:0]    s_tuser,
	input logic                                s_tlast,
	input logic                                m_tvalid,
	input logic                                m_tready
);

	logic take_speed;
	logic take_sample;
	logic take_last;

	assign take_speed  = s_tvalid && s_tready && !s_tuser[0];
	assign take_sample = s_tvalid && s_tready && s_tuser[0];
	assign take_last   = take_sample && s_tlast;

	// a pending result stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before it was taken");

	// a speed update leaves the input open
	a_speed_fast: assert property (@(posedge clk) disable iff (!arst_n)
		take_speed |=> s_tready)
		else $error("input closed after a speed update");

	// a range sample keeps the input closed while it is worked on
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take_sample |=> !s_tready)
		else $error("input open while a sample is in flight");

	// a fresh result follows a taken last sample
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(take_last, 5))
		else $error("result without a matching last sample");

endmodule

bind lidar_ttc_emergency_brake ltteb_checker u_ltteb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

/* dv/ltteb_checker.sv */
// ----------------------------------------------------------------------------
// ltteb_scoreboard
// Watches the sample, result and register write channels of the lidar
// time-to-collision brake. Keeps its own copy of the registers and the scan
// state, works out the brake flag of every finished scan and compares each
// result against the oldest outstanding flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ltteb_scoreboard #(
	parameter int DEPTH = ltteb_pkg::COS_TABLE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	// [15:0] speed_mm_s, [31:16] range_mm
	input  logic [ltteb_pkg::TDATA_IN_W-1:0]    s_tdata,
	// [0] cmd, [1] range_valid
	input  logic [ltteb_pkg::TUSER_IN_W-1:0]    s_tuser,
	input  logic                                s_tlast,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] brake, [7:1] zero
	input  logic [ltteb_pkg::TDATA_OUT_W-1:0]   m_tdata,
	input  logic                                cfg_we,
	input  logic [ltteb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ltteb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output int                                  failures,
	output int                                  pending,
	output int                                  samples_seen,
	output int                                  results_seen,
	output int                                  brakes_seen
);

	// mm to mm*1000 ms/s, times the Q14 scale of the cosine
	localparam longint RANGE_SCALE = 64'd16384000;

	// register copies
	logic signed [ltteb_pkg::ANGLE_W-1:0] start_q;
	logic signed [ltteb_pkg::ANGLE_W-1:0] stop_q;
	logic [ltteb_pkg::STEP_W-1:0]         step_q;
	logic [ltteb_pkg::LIMIT_W-1:0]        limit_q;

	// scan state
	logic signed [ltteb_pkg::SPEED_W-1:0] speed_q;
	int                                   beam_pos;
	logic                                 hit_seen;

	// brake flags of finished scans, oldest first
	logic                                 brake_due[$];

	int                                   cosine_rom[DEPTH];

	// sine over a quarter turn, z in Q14 from 0 to 16384
	function automatic longint sweep_sine(longint z);
		longint zz;
		longint poly;
		zz   = (z * z) >> 14;
		poly = 10584 - ((zz * 1232) >> 14);
		poly = 25736 - ((zz * poly) >> 14);
		return (z * poly) >> 14;
	endfunction

	// Q14 cosine of a binary angle from 0 to 65535
	function automatic int cos_from_angle(int a);
		int r;
		r = a % 16384;
		case (a / 16384)
			0: return int'(sweep_sine(16384 - r));
			1: return -int'(sweep_sine(r));
			2: return -int'(sweep_sine(16384 - r));
			default: return int'(sweep_sine(r));
		endcase
	endfunction

	// nearest table entry for a beam angle, wrapped to one turn
	function automatic int cos_at_beam(int ang);
		int a16;
		int idx;
		a16 = ang & 32'h0000FFFF;
		idx = (a16 * DEPTH + 32768) >>> 16;
		if (idx >= DEPTH)
			idx -= DEPTH;
		return cosine_rom[idx];
	endfunction

	initial begin : fill_rom
		for (int i = 0; i < DEPTH; i++)
			cosine_rom[i] = cos_from_angle((i * 65536) / DEPTH);
	end

	// predict and compare on every accepted item
	always @(posedge clk or negedge arst_n) begin : watch
		logic   want;
		logic   crit;
		longint rate;
		if (!arst_n) begin
			start_q      = ltteb_pkg::ANGLE_START_RST;
			stop_q       = ltteb_pkg::ANGLE_STOP_RST;
			step_q       = ltteb_pkg::ANGLE_STEP_RST;
			limit_q      = ltteb_pkg::TTC_LIMIT_RST;
			speed_q      = '0;
			beam_pos     = int'(ltteb_pkg::ANGLE_START_RST);
			hit_seen     = 1'b0;
			brake_due.delete();
			failures     = 0;
			pending      = 0;
			samples_seen = 0;
			results_seen = 0;
			brakes_seen  = 0;
		end else begin
			// result side
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tdata[0])
					brakes_seen++;
				if (brake_due.size() == 0) begin
					failures++;
					$display("%0t: result with none outstanding, expected nothing, got tdata %h",
						$time, m_tdata);
				end else begin
					want = brake_due.pop_front();
					if (m_tdata[0] !== want) begin
						failures++;
						$display("%0t: brake mismatch, expected %b, got %b",
							$time, want, m_tdata[0]);
					end
					if (m_tdata[ltteb_pkg::TDATA_OUT_W-1:1] !== '0) begin
						failures++;
						$display("%0t: tdata pad mismatch, expected %h, got %h",
							$time, {(ltteb_pkg::TDATA_OUT_W-1){1'b0}},
							m_tdata[ltteb_pkg::TDATA_OUT_W-1:1]);
					end
				end
			end

			// register writes
			if (cfg_we) begin
				case (cfg_index)
					ltteb_pkg::REG_ANGLE_START: begin
						start_q  = cfg_wdata;
						beam_pos = int'(start_q);
					end
					ltteb_pkg::REG_ANGLE_STOP:  stop_q  = cfg_wdata;
					ltteb_pkg::REG_ANGLE_STEP:  step_q  = cfg_wdata[ltteb_pkg::STEP_W-1:0];
					ltteb_pkg::REG_TTC_LIMIT:   limit_q = cfg_wdata;
					default: ;
				endcase
			end

			// item side
			if (s_tvalid && s_tready) begin
				if (!s_tuser[0]) begin
					speed_q = s_tdata[15:0];
				end else begin
					samples_seen++;
					crit = 1'b0;
					// beams past the stop angle hold the angle and never count
					if (beam_pos <= int'(stop_q)) begin
						rate = longint'(speed_q) * longint'(cos_at_beam(beam_pos));
						if (rate > 0 && s_tuser[1])
							crit = (longint'(s_tdata[31:16]) * RANGE_SCALE)
								< (longint'(limit_q) * rate);
						beam_pos += int'(step_q);
					end
					if (crit)
						hit_seen = 1'b1;
					// end of scan: one flag, fresh sweep
					if (s_tlast) begin
						brake_due = {brake_due, hit_seen};
						hit_seen  = 1'b0;
						beam_pos  = int'(start_q);
					end
				end
			end
			pending = brake_due.size();
		end
	end

endmodule

/* dv/tb_lidar_ttc_emergency_brake.sv */
// ----------------------------------------------------------------------------
// tb_lidar_ttc_emergency_brake
// Drives speed updates and lidar range samples into the brake block under
// several register settings, with bursty input, a stalling result side and
// one long result hold-off. A side checker predicts every brake result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lidar_ttc_emergency_brake;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [ltteb_pkg::TDATA_IN_W-1:0]    s_tdata;
	logic [ltteb_pkg::TUSER_IN_W-1:0]    s_tuser;
	logic                                s_tlast;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [ltteb_pkg::TDATA_OUT_W-1:0]   m_tdata;
	logic                                cfg_we;
	logic [ltteb_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [ltteb_pkg::CFG_DATA_W-1:0]    cfg_wdata;

	int failures;
	int pending;
	int samples_seen;
	int results_seen;
	int brakes_seen;

	int cycle_count;
	int sent;
	int burst_left;
	int settings_run;
	bit no_gaps;
	bit hold_req;

	lidar_ttc_emergency_brake dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	ltteb_scoreboard u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.failures     (failures),
		.pending      (pending),
		.samples_seen (samples_seen),
		.results_seen (results_seen),
		.brakes_seen  (brakes_seen)
	);

	initial begin : clock_gen
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: short runs and stalls, long ready stretches, one long hold
	initial begin : sink
		int run_left;
		int stall_left;
		run_left   = 0;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (run_left > 0)
					run_left--;
				else begin
					run_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
						: $urandom_range(0, 6);
					stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end
			end
		end
	end

	// offer one item, return at the falling edge after it was taken or after a burst gap
	task automatic put_item(input logic cmd, input logic [15:0] spd, input logic [15:0] rng,
		input logic vld, input logic lst);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {rng, spd};
		s_tuser  <= {vld, cmd};
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		sent++;
		// burst bookkeeping, gap between bursts
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 20);
			if (!no_gaps && $urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 8);
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// speed update, range side filled with noise
	task automatic send_speed(input logic [15:0] spd);
		put_item(1'b0, spd, 16'($urandom), 1'($urandom), 1'($urandom));
	endtask

	function automatic logic [15:0] pick_speed();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1, 2: return 16'($urandom_range(20000, 32767));
			3: return 16'($urandom_range(500, 20000));
			4: return 16'(-int'($urandom_range(1, 32768)));
			default: return 16'($urandom_range(0, 2));
		endcase
	endfunction

	function automatic logic [15:0] pick_range();
		case ($urandom_range(0, 5))
			0, 1: return 16'($urandom);
			2, 3: return 16'($urandom_range(0, 4000));
			4: return 16'($urandom_range(0, 600));
			default: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
		endcase
	endfunction

	// one scan: optional speed, samples with the odd speed change, last marked
	task automatic send_scan(input int len);
		if ($urandom_range(0, 3) != 0)
			send_speed(pick_speed());
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_speed(pick_speed());
			put_item(1'b1, 16'($urandom), pick_range(), $urandom_range(0, 7) != 0,
				i == len - 1);
		end
	endtask

	task automatic run_random(input int n);
		int first;
		int len;
		first = sent;
		while (sent - first < n) begin
			case ($urandom_range(0, 19))
				0: len = $urandom_range(60, 120);
				1, 2, 3: len = $urandom_range(13, 40);
				4: len = 0;
				default: len = $urandom_range(1, 12);
			endcase
			// stray item of any kind
			if (len == 0)
				put_item(1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
					1'($urandom));
			else
				send_scan(len);
		end
	endtask

	// stop offering and let every result and the pipeline drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input ltteb_pkg::cfg_reg_t idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [15:0] a_first, input logic [15:0] a_last,
		input logic [12:0] stp, input logic [15:0] lim);
		settle();
		write_reg(ltteb_pkg::REG_ANGLE_START, a_first);
		write_reg(ltteb_pkg::REG_ANGLE_STOP, a_last);
		write_reg(ltteb_pkg::REG_ANGLE_STEP, {3'b000, stp});
		write_reg(ltteb_pkg::REG_TTC_LIMIT, lim);
		settings_run++;
	endtask

	initial begin : stimulus
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] swap;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		s_tlast      = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = ltteb_pkg::REG_ANGLE_START;
		cfg_wdata    = '0;
		sent         = 0;
		burst_left   = 0;
		settings_run = 1;
		no_gaps      = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed, reset register values, first beam at -135 degrees
		// sample before any speed: zero rate
		put_item(1'b1, 16'h0000, 16'h0000, 1'b1, 1'b1);
		// speed update with every ignored field set
		put_item(1'b0, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1);
		// forward speed against a rear beam: negative rate
		put_item(1'b1, 16'h0000, 16'h0000, 1'b1, 1'b1);
		// most negative speed makes the rear rate positive
		put_item(1'b0, 16'h8000, 16'h0000, 1'b0, 1'b0);
		put_item(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		put_item(1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0);
		put_item(1'b1, 16'h0000, 16'h0000, 1'b1, 1'b1);
		// zero speed
		put_item(1'b0, 16'h0000, 16'h1234, 1'b0, 1'b1);
		put_item(1'b1, 16'h0000, 16'h0000, 1'b1, 1'b1);
		// open scan left behind; the start write below must reload the angle
		put_item(1'b0, 16'h7FFF, 16'h0000, 1'b0, 1'b0);
		put_item(1'b1, 16'h0000, 16'd100, 1'b1, 1'b0);
		put_item(1'b1, 16'h0000, 16'd200, 1'b1, 1'b0);

		// widest sweep, coarse step, largest limit: beams run past stop
		set_config(16'h8000, 16'h7FFF, 13'd4096, 16'hFFFF);
		run_random(220);
		// zero limit, one beam sweep
		set_config(16'h0000, 16'h0000, 13'd1, 16'h0000);
		run_random(150);
		// start past stop
		set_config(16'h4000, 16'hC000, 13'd100, 16'd2000);
		run_random(100);
		// zero step holds every beam at the start angle
		set_config(16'hE000, 16'h2000, 13'd0, 16'd1250);
		run_random(150);
		// top angle, then past stop at once
		set_config(16'h7FFF, 16'h7FFF, 13'd4096, 16'hFFFF);
		run_random(100);

		// back-pressure: long result hold while short scans keep coming
		set_config(16'hF000, 16'h1000, 13'd512, 16'd3000);
		hold_req = 1'b1;
		no_gaps  = 1'b1;
		begin : pressure
			int first;
			first = sent;
			while (sent - first < 80)
				send_scan($urandom_range(1, 2));
		end
		no_gaps = 1'b0;

		// random settings, mostly ordered sweeps
		for (int k = 0; k < 4; k++) begin
			a = 16'($urandom);
			b = 16'($urandom);
			if (k < 3 && $signed(a) > $signed(b)) begin
				swap = a;
				a    = b;
				b    = swap;
			end
			set_config(a, b, 13'($urandom_range(1, 4096)), 16'($urandom));
			run_random(200);
		end

		// reset values again
		set_config(ltteb_pkg::ANGLE_START_RST, ltteb_pkg::ANGLE_STOP_RST,
			ltteb_pkg::ANGLE_STEP_RST, ltteb_pkg::TTC_LIMIT_RST);
		run_random(200);
		settle();

		$display("sent %0d items (%0d range samples) over %0d register settings",
			sent, samples_seen, settings_run);
		$display("checked %0d brake results, %0d of them braking", results_seen, brakes_seen);
		if (failures == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
